### rtl/cms_pkg.sv
// package for the count-min sketch: widths, command codes, hash constants
// and the structs passed between the front and back parts
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cms_pkg;

    // payload widths
    localparam int CMD_W   = 2;
    localparam int ITEM_W  = 32;
    localparam int COUNT_W = 32;

    // default sketch geometry
    localparam int ROWS_DEFAULT    = 4;
    localparam int BUCKETS_DEFAULT = 128;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // finalizer constants
    localparam logic [ITEM_W-1:0] MIX_C1 = 32'h85eb_ca6b;
    localparam logic [ITEM_W-1:0] MIX_C2 = 32'hc2b2_ae35;
    localparam int MIX_SHIFT_A = 16;
    localparam int MIX_SHIFT_B = 13;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    // one queued operation
    typedef struct packed {
        cmd_t              op;
        logic [ITEM_W-1:0] item;
    } op_t;

    // head of the queue as seen by the back part
    typedef struct packed {
        logic valid;
        op_t  entry;
    } queue_head_t;

    // status reported by the back part
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

`default_nettype wire

### rtl/cms_if.sv
// valid/ready channel interfaces for the count-min sketch
// depends on cms_pkg
`timescale 1ns / 1ps
`default_nettype none

// command channel: command and item
interface cms_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [cms_pkg::CMD_W-1:0]    command;
    logic [cms_pkg::ITEM_W-1:0]   item;

    modport source (output valid, output command, output item, input ready);
    modport sink   (input valid, input command, input item, output ready);
endinterface

// result channel: count estimate
interface cms_result_if;
    logic                         valid;
    logic                         ready;
    logic [cms_pkg::COUNT_W-1:0]  count_estimate;

    modport source (output valid, output count_estimate, input ready);
    modport sink   (input valid, input count_estimate, output ready);
endinterface

`default_nettype wire

### rtl/cms_front.sv
// front part of the count-min sketch: takes command transactions, drops
// the unused code and queues the rest for the back part
// depends on cms_pkg and cms_if
`timescale 1ns / 1ps
`default_nettype none

module cms_front (
    input  wire                    clk,
    input  wire                    rst_n,
    cms_cmd_if.sink                cmd,
    input  cms_pkg::back_status_t  status,
    output cms_pkg::queue_head_t   head,
    input  wire                    pop
);

    localparam int QPW = (cms_pkg::QUEUE_DEPTH > 1) ? $clog2(cms_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(cms_pkg::QUEUE_DEPTH + 1);

    cms_pkg::op_t     slots [cms_pkg::QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             accept;
    logic             is_op;
    logic             push;

    // classify the incoming transaction
    assign cmd.ready = !status.clearing && (count_reg != QCW'(cms_pkg::QUEUE_DEPTH));
    assign accept    = cmd.valid && cmd.ready;
    assign is_op     = (cmd.command == cms_pkg::CMD_INSERT)
                    || (cmd.command == cms_pkg::CMD_REMOVE)
                    || (cmd.command == cms_pkg::CMD_QUERY);
    assign push      = accept && is_op;

    // queue head
    assign head.valid = (count_reg != '0);
    assign head.entry = slots[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(cms_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(cms_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= '{op: cms_pkg::cmd_t'(cmd.command), item: cmd.item};
        end
    end

endmodule

`default_nettype wire

### rtl/cms_back.sv
// back part of the count-min sketch: clears the counter memory after reset,
// then per row hashes the item, reduces it to a bucket and updates or reads
// the counter; queries leave through an output register
// depends on cms_pkg and cms_if
`timescale 1ns / 1ps
`default_nettype none

module cms_back #(
    parameter int ROWS    = cms_pkg::ROWS_DEFAULT,
    parameter int BUCKETS = cms_pkg::BUCKETS_DEFAULT
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  cms_pkg::queue_head_t   head,
    output logic                   pop,
    output cms_pkg::back_status_t  status,
    cms_result_if.source           result
);

    localparam int DEPTH   = ROWS * BUCKETS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW      = $clog2(BUCKETS);
    localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IW      = cms_pkg::ITEM_W;
    localparam int CNW     = cms_pkg::COUNT_W;
    // scaled reciprocal of the bucket count, fits in IW bits
    localparam int QSH     = IW - 1 + BW;
    localparam logic [2*IW-1:0] RECIP_WIDE = ((2*IW)'(1) << QSH) / (2*IW)'(BUCKETS);
    localparam logic [IW-1:0]   RECIP      = RECIP_WIDE[IW-1:0];
    localparam logic [IW-1:0]   BUCKET_IW  = IW'(BUCKETS);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b0_0000_0001,
        S_IDLE   = 9'b0_0000_0010,
        S_MUL1   = 9'b0_0000_0100,
        S_MUL2   = 9'b0_0000_1000,
        S_DIV    = 9'b0_0001_0000,
        S_MOD    = 9'b0_0010_0000,
        S_READ   = 9'b0_0100_0000,
        S_UPDATE = 9'b0_1000_0000,
        S_EMIT   = 9'b1_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNW-1:0]    out_data_reg, out_data_next;
    cms_pkg::cmd_t     op_reg, op_next;
    logic [IW-1:0]     item_reg, item_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [IW-1:0]     hash_reg, hash_next;
    logic [IW-1:0]     quot_reg, quot_next;
    logic [BW-1:0]     rem_reg, rem_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [CNW-1:0]    min_reg, min_next;
    logic [CNW-1:0]    rd_data_reg;

    logic [CNW-1:0]    mem [DEPTH];

    logic [IW-1:0]     h0, h0s, mul1, h1, mul2, mix;
    logic [2*IW-1:0]   prod;
    logic [IW-1:0]     fold, rem0, rem1, rem2;
    logic [AW-1:0]     rd_addr;
    logic [CNW-1:0]    upd_data;
    logic              rd_en;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CNW-1:0]    wr_data;

    // finalizer halves, each multiply lands in hash_reg
    assign h0   = item_reg ^ IW'(row_reg);
    assign h0s  = h0 ^ (h0 >> cms_pkg::MIX_SHIFT_A);
    assign mul1 = h0s * cms_pkg::MIX_C1;
    assign h1   = hash_reg ^ (hash_reg >> cms_pkg::MIX_SHIFT_B);
    assign mul2 = h1 * cms_pkg::MIX_C2;
    assign mix  = mul2 ^ (mul2 >> cms_pkg::MIX_SHIFT_A);

    // bucket reduction: quotient estimate by reciprocal, then at most two corrections
    assign prod = (2*IW)'(hash_reg) * (2*IW)'(RECIP);
    assign fold = quot_reg * BUCKET_IW;
    assign rem0 = hash_reg - fold;
    assign rem1 = (rem0 >= BUCKET_IW) ? rem0 - BUCKET_IW : rem0;
    assign rem2 = (rem1 >= BUCKET_IW) ? rem1 - BUCKET_IW : rem1;

    // counter address and updated value
    assign rd_addr = base_reg + AW'(rem_reg);

    always_comb
    begin
        unique case (op_reg)
            cms_pkg::CMD_INSERT: upd_data = rd_data_reg + 1'b1;
            cms_pkg::CMD_REMOVE: upd_data = rd_data_reg - 1'b1;
            default:             upd_data = rd_data_reg;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        op_next        = op_reg;
        item_next      = item_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        hash_next      = hash_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        addr_next      = addr_reg;
        min_next       = min_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = upd_data;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    op_next    = head.entry.op;
                    item_next  = head.entry.item;
                    row_next   = '0;
                    base_next  = '0;
                    min_next   = '1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                hash_next  = mul1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                hash_next  = mix;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                quot_next  = IW'(prod >> QSH);
                state_next = S_MOD;
            end
            S_MOD:
            begin
                rem_next   = rem2[BW-1:0];
                state_next = S_READ;
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                addr_next  = rd_addr;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                wr_en = (op_reg != cms_pkg::CMD_QUERY);
                if ((op_reg == cms_pkg::CMD_QUERY) && (rd_data_reg < min_reg))
                begin
                    min_next = rd_data_reg;
                end
                if (row_reg == RW'(ROWS - 1))
                begin
                    state_next = (op_reg == cms_pkg::CMD_QUERY) ? S_EMIT : S_IDLE;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    base_next  = base_reg + AW'(BUCKETS);
                    state_next = S_MUL1;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = min_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        op_reg       <= op_next;
        item_reg     <= item_next;
        row_reg      <= row_next;
        base_reg     <= base_next;
        hash_reg     <= hash_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        addr_reg     <= addr_next;
        min_reg      <= min_next;
    end

    // counter memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // counter memory read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // outputs
    assign status.clearing       = (state_reg == S_CLEAR);
    assign result.valid          = out_valid_reg;
    assign result.count_estimate = out_data_reg;

endmodule

`default_nettype wire

### rtl/count_min_sketch.sv
// count-min sketch, ROWS x BUCKETS 32-bit counters in one memory
// the back sequencer works on one operation at a time, per row in two multiply, two bucket
// reduction, one read and one update step; the front queue holds up to two more operations
// a query result waits in the back output register while result stalls
// reset: asynchronous, then a clearing pass over all ROWS*BUCKETS counters with ready low
// depends on cms_pkg, cms_if, cms_front and cms_back
`timescale 1ns / 1ps
`default_nettype none

module count_min_sketch #(
    parameter int ROWS    = cms_pkg::ROWS_DEFAULT,
    parameter int BUCKETS = cms_pkg::BUCKETS_DEFAULT
) (
    input  wire           clk,
    input  wire           rst_n,
    cms_cmd_if.sink       cmd,
    cms_result_if.source  result
);

    cms_pkg::queue_head_t   head;
    cms_pkg::back_status_t  status;
    logic                   pop;

    // accept and queue transactions
    cms_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .head   (head),
        .pop    (pop)
    );

    // hash, update and answer
    cms_back #(
        .ROWS    (ROWS),
        .BUCKETS (BUCKETS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .status (status),
        .result (result)
    );

endmodule

`default_nettype wire

### rtl/cms_checker.sv
// port-level checks for the count-min sketch, bound to the top level
// depends on cms_pkg and count_min_sketch
`timescale 1ns / 1ps
`default_nettype none

module cms_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          cmd_ready,
    input wire                          result_valid,
    input wire                          result_ready,
    input wire [cms_pkg::COUNT_W-1:0]   count_estimate
);

    // a waiting result is not withdrawn
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped before transaction");

    // a waiting result keeps its value
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(count_estimate))
        else $error("count estimate changed while stalled");

    // clearing pass holds off traffic on leaving reset
    a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !cmd_ready && !result_valid)
        else $error("block active at end of reset");

    // ready and result valid are still low in the cycle after reset is released
    a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |=> !cmd_ready && !result_valid)
        else $error("clearing pass too short");

endmodule

bind count_min_sketch cms_checker u_cms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_ready      (cmd.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .count_estimate (result.count_estimate)
);

`default_nettype wire
